// ===== rtl/tick_sorted_history_buffer_macros.svh =====
// assertion macros shared by the history buffer modules
`ifndef TICK_SORTED_HISTORY_BUFFER_MACROS_SVH
`define TICK_SORTED_HISTORY_BUFFER_MACROS_SVH
// same-cycle implication, disabled in reset
`define TSH_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tsh assertion failed");
// next-cycle implication, disabled in reset
`define TSH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tsh assertion failed");
`endif

// ===== rtl/tsh_pkg.sv =====
// shared types and constants of the tick sorted history buffer
`timescale 1ns / 1ps
package tsh_pkg;
  localparam int STORE_DEPTH_DEF  = 16;
  localparam int PAYLOAD_BITS_DEF = 64;
  localparam int TICK_W           = 32;
  localparam int DATA_W           = 64;
  localparam int DEPTH_W          = 5;
  localparam int MODE_W           = 3;

  // operation codes of an input item
  localparam logic [MODE_W-1:0] MODE_PUSH_IN   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_SNAP = 3'd1;
  localparam logic [MODE_W-1:0] MODE_PUSH_EVT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_QUERY_IN  = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QUERY_SNAP = 3'd4;
  localparam logic [MODE_W-1:0] MODE_COMPACT   = 3'd5;

  // register indexes of the configuration port
  localparam logic REG_DEPTH = 1'b0;
  localparam logic REG_KEEP  = 1'b1;

  typedef enum logic [2:0] {ST_NOP, ST_INS, ST_INS_DROP, ST_REPL, ST_DROP} st_op_t;
  typedef enum logic [1:0] {SEL_IN, SEL_SNAP, SEL_EVT} sel_t;
  typedef enum logic [2:0] {
    RES_NONE, RES_PEND_LOAD, RES_EMIT_PEND_LOAD, RES_EMIT_PEND_LAST, RES_EMIT_NONE,
    RES_EMIT_HIT
  } res_op_t;
  typedef enum logic [2:0] {S_IDLE, S_PUSH, S_TRIM, S_COMPACT, S_QIN, S_QSNAP} state_t;

  typedef struct packed {
    logic    latch;
    st_op_t  op_in;
    st_op_t  op_snap;
    st_op_t  op_evt;
    logic    rd_snap;
    res_op_t res;
  } dp_cmd_t;

  typedef struct packed {
    logic hit;
    logic lt_in;
    logic lt_snap;
    logic lt_evt;
    logic eq_snap;
  } dp_stat_t;
endpackage

// ===== rtl/tick_sorted_history_buffer.sv =====
// top level: configuration registers, controller and datapath
`timescale 1ns / 1ps
// Keeps three tick-ordered stores (inputs, snapshots, events) of up to STORE_DEPTH
// entries. An item is taken when start is high and busy is low. A push stores the
// item, then drops the oldest entries one at a time until history_depth is met;
// compaction drops the entries below the item's tick from each store in turn; an
// input query scans all stored entries and a snapshot query up to its first hit,
// one entry per cycle. Results appear on out_* for one cycle with out_valid high
// and cannot be stalled by the receiver. Write configuration only while busy is low.
module tick_sorted_history_buffer #(
  parameter int STORE_DEPTH  = tsh_pkg::STORE_DEPTH_DEF,
  parameter int PAYLOAD_BITS = tsh_pkg::PAYLOAD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [tsh_pkg::MODE_W-1:0]  in_mode,
  input  logic [tsh_pkg::TICK_W-1:0]  in_tick,
  input  logic [tsh_pkg::DATA_W-1:0]  in_entry_data,
  output logic                        out_valid,
  output logic                        out_found,
  output logic [tsh_pkg::TICK_W-1:0]  out_found_tick,
  output logic [tsh_pkg::DATA_W-1:0]  out_found_data,
  output logic                        out_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import tsh_pkg::*;
  localparam int CW = $clog2(STORE_DEPTH + 1);
  localparam int IW = $clog2(STORE_DEPTH);

  logic [DEPTH_W-1:0] depth_r;
  logic               keep_r;
  dp_cmd_t            cmd;
  dp_stat_t           stat;
  logic [IW-1:0]      rd_idx;
  logic [CW-1:0]      cnt_in, cnt_snap, cnt_evt;

  // configuration register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= DEPTH_W'(16);
      keep_r  <= 1'b1;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_DEPTH: depth_r <= pwdata[DEPTH_W-1:0];
        REG_KEEP:  keep_r  <= pwdata[0];
        default: ;
      endcase
    end
  end

  // configuration readback
  always_comb begin
    case (paddr[2])
      REG_DEPTH: prdata = {{(32-DEPTH_W){1'b0}}, depth_r};
      default:   prdata = {31'b0, keep_r};
    endcase
  end
  assign pready = 1'b1;

  tsh_ctrl #(.STORE_DEPTH(STORE_DEPTH)) u_ctrl (
    .clk, .rst_n, .start, .in_mode, .depth(depth_r), .keep(keep_r), .stat,
    .cnt_in, .cnt_snap, .cnt_evt, .cmd, .rd_idx, .busy
  );

  tsh_datapath #(.STORE_DEPTH(STORE_DEPTH), .PAYLOAD_BITS(PAYLOAD_BITS)) u_dp (
    .clk, .rst_n, .cmd, .rd_idx, .in_tick, .in_entry_data, .stat,
    .cnt_in, .cnt_snap, .cnt_evt, .out_valid, .out_found, .out_found_tick,
    .out_found_data, .out_last
  );
endmodule

// ===== rtl/tsh_store.sv =====
// one tick-ordered store: a row of entry cells with sorted insert, payload replace and front drop
`timescale 1ns / 1ps
`include "tick_sorted_history_buffer_macros.svh"
module tsh_store #(
  parameter int STORE_DEPTH  = tsh_pkg::STORE_DEPTH_DEF,
  parameter int PAYLOAD_BITS = tsh_pkg::PAYLOAD_BITS_DEF,
  localparam int CW = $clog2(STORE_DEPTH + 1),
  localparam int IW = $clog2(STORE_DEPTH)
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  tsh_pkg::st_op_t          op,
  input  logic [tsh_pkg::TICK_W-1:0] tk,
  input  logic [PAYLOAD_BITS-1:0]  dat,
  input  logic [IW-1:0]            rd_idx,
  output logic [CW-1:0]            count,
  output logic [tsh_pkg::TICK_W-1:0] front_tick,
  output logic [tsh_pkg::TICK_W-1:0] rd_tick,
  output logic [PAYLOAD_BITS-1:0]  rd_data,
  output logic                     has_eq
);
  import tsh_pkg::*;

  logic [TICK_W-1:0]       tick_r [STORE_DEPTH];
  logic [PAYLOAD_BITS-1:0] pay_r  [STORE_DEPTH];
  logic [CW-1:0]           count_r, count_nxt;
  logic [STORE_DEPTH-1:0]  vld, le;
  logic [TICK_W-1:0]       ins_tick [STORE_DEPTH+1];
  logic [PAYLOAD_BITS-1:0] ins_pay  [STORE_DEPTH+1];

  // per-cell compares against the pushed tick
  always_comb begin
    has_eq = 1'b0;
    for (int i = 0; i < STORE_DEPTH; i++) begin
      vld[i] = CW'(i) < count_r;
      le[i]  = vld[i] && (tick_r[i] <= tk);
      has_eq = has_eq | (vld[i] && (tick_r[i] == tk));
    end
  end

  // list with the new entry placed after all smaller or equal ticks
  always_comb begin
    if (le[0]) begin
      ins_tick[0] = tick_r[0];
      ins_pay[0]  = pay_r[0];
    end else begin
      ins_tick[0] = tk;
      ins_pay[0]  = dat;
    end
    for (int j = 1; j <= STORE_DEPTH; j++) begin
      if (j < STORE_DEPTH && le[j % STORE_DEPTH]) begin
        ins_tick[j] = tick_r[j % STORE_DEPTH];
        ins_pay[j]  = pay_r[j % STORE_DEPTH];
      end else if (le[j-1]) begin
        ins_tick[j] = tk;
        ins_pay[j]  = dat;
      end else begin
        ins_tick[j] = tick_r[j-1];
        ins_pay[j]  = pay_r[j-1];
      end
    end
  end

  // entry cells, no reset on payload
  always_ff @(posedge clk) begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      case (op)
        ST_INS: begin
          tick_r[i] <= ins_tick[i];
          pay_r[i]  <= ins_pay[i];
        end
        ST_INS_DROP: begin
          tick_r[i] <= ins_tick[i+1];
          pay_r[i]  <= ins_pay[i+1];
        end
        ST_REPL: begin
          if (vld[i] && tick_r[i] == tk) pay_r[i] <= dat;
        end
        ST_DROP: begin
          if (i < STORE_DEPTH - 1) begin
            tick_r[i] <= tick_r[(i+1) % STORE_DEPTH];
            pay_r[i]  <= pay_r[(i+1) % STORE_DEPTH];
          end
        end
        default: ;
      endcase
    end
  end

  // fill count
  always_comb begin
    case (op)
      ST_INS:  count_nxt = count_r + CW'(1);
      ST_DROP: count_nxt = count_r - CW'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) count_r <= '0;
    else count_r <= count_nxt;
  end

  assign count      = count_r;
  assign front_tick = tick_r[0];
  assign rd_tick    = tick_r[rd_idx];
  assign rd_data    = pay_r[rd_idx];

  `TSH_ASSERT_IMPL(a_count_bound, 1'b1, count_r <= CW'(STORE_DEPTH))
  `TSH_ASSERT_IMPL(a_ins_not_full, op == ST_INS, count_r != CW'(STORE_DEPTH))
  `TSH_ASSERT_NEXT(a_drop_dec, op == ST_DROP, count_r == $past(count_r) - CW'(1))
endmodule

// ===== rtl/tsh_datapath.sv =====
// datapath: three stores, held item fields, pending match and result registers
`timescale 1ns / 1ps
module tsh_datapath #(
  parameter int STORE_DEPTH  = tsh_pkg::STORE_DEPTH_DEF,
  parameter int PAYLOAD_BITS = tsh_pkg::PAYLOAD_BITS_DEF,
  localparam int CW = $clog2(STORE_DEPTH + 1),
  localparam int IW = $clog2(STORE_DEPTH)
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  tsh_pkg::dp_cmd_t           cmd,
  input  logic [IW-1:0]              rd_idx,
  input  logic [tsh_pkg::TICK_W-1:0] in_tick,
  input  logic [tsh_pkg::DATA_W-1:0] in_entry_data,
  output tsh_pkg::dp_stat_t          stat,
  output logic [CW-1:0]              cnt_in,
  output logic [CW-1:0]              cnt_snap,
  output logic [CW-1:0]              cnt_evt,
  output logic                       out_valid,
  output logic                       out_found,
  output logic [tsh_pkg::TICK_W-1:0] out_found_tick,
  output logic [tsh_pkg::DATA_W-1:0] out_found_data,
  output logic                       out_last
);
  import tsh_pkg::*;

  logic [TICK_W-1:0]       tick_r, pend_tick_r;
  logic [PAYLOAD_BITS-1:0] data_r, pend_data_r;
  logic [TICK_W-1:0]       ft_in, ft_snap, ft_evt, rt_in, rt_snap, rt_evt, rd_tick;
  logic [PAYLOAD_BITS-1:0] rd_in, rd_snap, rd_evt, rd_data;
  logic                    eq_in, eq_snap, eq_evt;
  logic                    valid_r, found_r, last_r;
  logic [TICK_W-1:0]       otick_r;
  logic [PAYLOAD_BITS-1:0] odata_r;

  // hold the accepted item
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      tick_r <= in_tick;
      data_r <= in_entry_data[PAYLOAD_BITS-1:0];
    end
  end

  tsh_store #(.STORE_DEPTH(STORE_DEPTH), .PAYLOAD_BITS(PAYLOAD_BITS)) u_in (
    .clk, .rst_n, .op(cmd.op_in), .tk(tick_r), .dat(data_r), .rd_idx,
    .count(cnt_in), .front_tick(ft_in), .rd_tick(rt_in), .rd_data(rd_in), .has_eq(eq_in)
  );
  tsh_store #(.STORE_DEPTH(STORE_DEPTH), .PAYLOAD_BITS(PAYLOAD_BITS)) u_snap (
    .clk, .rst_n, .op(cmd.op_snap), .tk(tick_r), .dat(data_r), .rd_idx,
    .count(cnt_snap), .front_tick(ft_snap), .rd_tick(rt_snap), .rd_data(rd_snap),
    .has_eq(eq_snap)
  );
  tsh_store #(.STORE_DEPTH(STORE_DEPTH), .PAYLOAD_BITS(PAYLOAD_BITS)) u_evt (
    .clk, .rst_n, .op(cmd.op_evt), .tk(tick_r), .dat(data_r), .rd_idx,
    .count(cnt_evt), .front_tick(ft_evt), .rd_tick(rt_evt), .rd_data(rd_evt),
    .has_eq(eq_evt)
  );

  // scan read select and status
  assign rd_tick = cmd.rd_snap ? rt_snap : rt_in;
  assign rd_data = cmd.rd_snap ? rd_snap : rd_in;
  always_comb begin
    stat.hit     = rd_tick == tick_r;
    stat.lt_in   = ft_in < tick_r;
    stat.lt_snap = ft_snap < tick_r;
    stat.lt_evt  = ft_evt < tick_r;
    stat.eq_snap = eq_snap;
  end

  // pending match and result payload
  always_ff @(posedge clk) begin
    case (cmd.res)
      RES_PEND_LOAD: begin
        pend_tick_r <= rd_tick;
        pend_data_r <= rd_data;
      end
      RES_EMIT_PEND_LOAD: begin
        found_r <= 1'b1; otick_r <= pend_tick_r; odata_r <= pend_data_r; last_r <= 1'b0;
        pend_tick_r <= rd_tick;
        pend_data_r <= rd_data;
      end
      RES_EMIT_PEND_LAST: begin
        found_r <= 1'b1; otick_r <= pend_tick_r; odata_r <= pend_data_r; last_r <= 1'b1;
      end
      RES_EMIT_NONE: begin
        found_r <= 1'b0; otick_r <= '0; odata_r <= '0; last_r <= 1'b1;
      end
      RES_EMIT_HIT: begin
        found_r <= 1'b1; otick_r <= rd_tick; odata_r <= rd_data; last_r <= 1'b1;
      end
      default: ;
    endcase
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= cmd.res == RES_EMIT_PEND_LOAD || cmd.res == RES_EMIT_PEND_LAST ||
                    cmd.res == RES_EMIT_NONE || cmd.res == RES_EMIT_HIT;
  end

  assign out_valid      = valid_r;
  assign out_found      = found_r;
  assign out_found_tick = otick_r;
  assign out_found_data = DATA_W'(odata_r);
  assign out_last       = last_r;
endmodule

// ===== rtl/tsh_ctrl.sv =====
// controller: sequences pushes, trims, compaction and query scans
`timescale 1ns / 1ps
`include "tick_sorted_history_buffer_macros.svh"
module tsh_ctrl #(
  parameter int STORE_DEPTH = tsh_pkg::STORE_DEPTH_DEF,
  localparam int CW = $clog2(STORE_DEPTH + 1),
  localparam int IW = $clog2(STORE_DEPTH)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [tsh_pkg::MODE_W-1:0]  in_mode,
  input  logic [tsh_pkg::DEPTH_W-1:0] depth,
  input  logic                        keep,
  input  tsh_pkg::dp_stat_t           stat,
  input  logic [CW-1:0]               cnt_in,
  input  logic [CW-1:0]               cnt_snap,
  input  logic [CW-1:0]               cnt_evt,
  output tsh_pkg::dp_cmd_t            cmd,
  output logic [IW-1:0]               rd_idx,
  output logic                        busy
);
  import tsh_pkg::*;
  localparam int LW = CW > DEPTH_W ? CW : DEPTH_W;

  state_t        state_r, state_nxt;
  sel_t          sel_r, sel_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic          pend_r, pend_nxt;
  logic [CW-1:0] sel_cnt;
  logic          sel_lt;
  logic [LW-1:0] lim;
  st_op_t        op;

  // limit is the smaller of the register and the store size
  assign lim = (LW'(depth) > LW'(STORE_DEPTH)) ? LW'(STORE_DEPTH) : LW'(depth);

  always_comb begin
    case (sel_r)
      SEL_IN:   begin sel_cnt = cnt_in;   sel_lt = stat.lt_in;   end
      SEL_SNAP: begin sel_cnt = cnt_snap; sel_lt = stat.lt_snap; end
      default:  begin sel_cnt = cnt_evt;  sel_lt = stat.lt_evt;  end
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    idx_nxt   = idx_r;
    pend_nxt  = pend_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          idx_nxt  = '0;
          pend_nxt = 1'b0;
          case (in_mode)
            MODE_PUSH_IN:    begin state_nxt = S_PUSH; sel_nxt = SEL_IN; end
            MODE_PUSH_SNAP:  begin state_nxt = S_PUSH; sel_nxt = SEL_SNAP; end
            MODE_PUSH_EVT:   begin
              if (keep) begin state_nxt = S_PUSH; sel_nxt = SEL_EVT; end
            end
            MODE_QUERY_IN:   state_nxt = S_QIN;
            MODE_QUERY_SNAP: state_nxt = S_QSNAP;
            MODE_COMPACT:    begin state_nxt = S_COMPACT; sel_nxt = SEL_IN; end
            default: ;
          endcase
        end
      end
      S_PUSH: state_nxt = S_TRIM;
      S_TRIM: begin
        if (LW'(sel_cnt) <= lim) state_nxt = S_IDLE;
      end
      S_COMPACT: begin
        if (!(sel_cnt != '0 && sel_lt)) begin
          case (sel_r)
            SEL_IN:   sel_nxt = SEL_SNAP;
            SEL_SNAP: sel_nxt = SEL_EVT;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end
      S_QIN: begin
        if (idx_r == cnt_in) begin
          state_nxt = S_IDLE;
          pend_nxt  = 1'b0;
        end else begin
          idx_nxt = idx_r + CW'(1);
          if (stat.hit) pend_nxt = 1'b1;
        end
      end
      S_QSNAP: begin
        if (idx_r == cnt_snap || stat.hit) state_nxt = S_IDLE;
        else idx_nxt = idx_r + CW'(1);
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd         = '0;
    cmd.op_in   = ST_NOP;
    cmd.op_snap = ST_NOP;
    cmd.op_evt  = ST_NOP;
    cmd.res     = RES_NONE;
    cmd.latch   = (state_r == S_IDLE) && start;
    cmd.rd_snap = state_r == S_QSNAP;
    op          = ST_NOP;
    case (state_r)
      S_PUSH: begin
        if (sel_r == SEL_SNAP && stat.eq_snap) op = ST_REPL;
        else if (sel_cnt == CW'(STORE_DEPTH)) op = ST_INS_DROP;
        else op = ST_INS;
      end
      S_TRIM:    if (LW'(sel_cnt) > lim) op = ST_DROP;
      S_COMPACT: if (sel_cnt != '0 && sel_lt) op = ST_DROP;
      S_QIN: begin
        if (idx_r == cnt_in) cmd.res = pend_r ? RES_EMIT_PEND_LAST : RES_EMIT_NONE;
        else if (stat.hit) cmd.res = pend_r ? RES_EMIT_PEND_LOAD : RES_PEND_LOAD;
      end
      S_QSNAP: begin
        if (idx_r == cnt_snap) cmd.res = RES_EMIT_NONE;
        else if (stat.hit) cmd.res = RES_EMIT_HIT;
      end
      default: ;
    endcase
    case (sel_r)
      SEL_IN:   cmd.op_in   = op;
      SEL_SNAP: cmd.op_snap = op;
      default:  cmd.op_evt  = op;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      sel_r   <= SEL_IN;
      idx_r   <= '0;
      pend_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
      idx_r   <= idx_nxt;
      pend_r  <= pend_nxt;
    end
  end

  assign rd_idx = idx_r[IW-1:0];
  assign busy   = state_r != S_IDLE;

  `TSH_ASSERT_IMPL(a_pend_in_query, pend_r, state_r == S_QIN)
  `TSH_ASSERT_NEXT(a_push_trims, state_r == S_PUSH, state_r == S_TRIM)
  `TSH_ASSERT_IMPL(a_scan_bound, state_r == S_QSNAP, idx_r <= cnt_snap)
endmodule

// ===== test/tick_sorted_history_buffer_checker.sv =====
// checker: mirrors the three stores, predicts query results and compares them
`timescale 1ns / 1ps
module tick_sorted_history_buffer_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic                        busy,
  input  logic [tsh_pkg::MODE_W-1:0]  in_mode,
  input  logic [tsh_pkg::TICK_W-1:0]  in_tick,
  input  logic [tsh_pkg::DATA_W-1:0]  in_entry_data,
  input  logic                        out_valid,
  input  logic                        out_found,
  input  logic [tsh_pkg::TICK_W-1:0]  out_found_tick,
  input  logic [tsh_pkg::DATA_W-1:0]  out_found_data,
  input  logic                        out_last,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [2:0]                  paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  output int                          fail_count,
  output int                          pending_count
);
  import tsh_pkg::*;

  localparam int DEPTH = STORE_DEPTH_DEF;

  typedef struct {
    logic [TICK_W-1:0] tick;
    logic [DATA_W-1:0] data;
  } entry_t;

  typedef struct {
    logic              found;
    logic [TICK_W-1:0] tick;
    logic [DATA_W-1:0] data;
    logic              last;
  } hit_t;

  entry_t in_store[$];
  entry_t snap_store[$];
  entry_t evt_store[$];
  hit_t   expected_hits[$];
  logic [DEPTH_W-1:0] depth_reg;
  logic               keep_reg;

  assign pending_count = expected_hits.size();

  // sorted insert or snapshot replace, then trim oldest down to the limit
  function automatic void push_entry(ref entry_t st[$], input logic [TICK_W-1:0] t,
                                     input logic [DATA_W-1:0] d, input bit replace);
    int pos;
    int lim;
    bit replaced;
    entry_t e;
    e.tick = t;
    e.data = d;
    replaced = 1'b0;
    if (replace) begin
      foreach (st[i]) begin
        if (!replaced && st[i].tick == t) begin
          st[i].data = d;
          replaced = 1'b1;
        end
      end
    end
    if (!replaced) begin
      pos = 0;
      while (pos < st.size() && st[pos].tick <= t) pos++;
      st.insert(pos, e);
    end
    // the limit applies after a replace too
    lim = (depth_reg < DEPTH) ? int'(depth_reg) : DEPTH;
    while (st.size() > lim) st.delete(0);
  endfunction

  function automatic void compact_store(ref entry_t st[$], input logic [TICK_W-1:0] t);
    while (st.size() > 0 && st[0].tick < t) st.delete(0);
  endfunction

  function automatic void add_hit(logic f, logic [TICK_W-1:0] t, logic [DATA_W-1:0] d,
                                  logic l);
    hit_t h;
    h.found = f;
    h.tick = t;
    h.data = d;
    h.last = l;
    expected_hits.insert(expected_hits.size(), h);
  endfunction

  always @(posedge clk) begin
    int n;
    bit got;
    hit_t h;
    if (!rst_n) begin
      in_store.delete();
      snap_store.delete();
      evt_store.delete();
      expected_hits.delete();
      depth_reg <= 5'd16;
      keep_reg <= 1'b1;
      fail_count <= 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_DEPTH) depth_reg <= pwdata[DEPTH_W-1:0];
        else keep_reg <= pwdata[0];
      end
      // compare a result transfer with the oldest expectation
      if (out_valid) begin
        if (expected_hits.size() == 0) begin
          $error("unexpected result found=%0d tick=%0h", out_found, out_found_tick);
          fail_count <= fail_count + 1;
        end else begin
          h = expected_hits[0];
          expected_hits.delete(0);
          n = 0;
          if (out_found !== h.found) begin
            $error("found exp %0h got %0h", h.found, out_found); n++;
          end
          if (out_found_tick !== h.tick) begin
            $error("found_tick exp %0h got %0h", h.tick, out_found_tick); n++;
          end
          if (out_found_data !== h.data) begin
            $error("found_data exp %0h got %0h", h.data, out_found_data); n++;
          end
          if (out_last !== h.last) begin
            $error("last exp %0h got %0h", h.last, out_last); n++;
          end
          if (n > 0) fail_count <= fail_count + 1;
        end
      end
      // predict on each accepted input transfer
      if (start && !busy) begin
        case (in_mode)
          MODE_PUSH_IN:   push_entry(in_store, in_tick, in_entry_data, 1'b0);
          MODE_PUSH_SNAP: push_entry(snap_store, in_tick, in_entry_data, 1'b1);
          MODE_PUSH_EVT:  if (keep_reg) push_entry(evt_store, in_tick, in_entry_data, 1'b0);
          MODE_QUERY_IN: begin
            n = 0;
            foreach (in_store[i]) begin
              if (in_store[i].tick == in_tick) begin
                add_hit(1'b1, in_store[i].tick, in_store[i].data, 1'b0);
                n++;
              end
            end
            if (n == 0) add_hit(1'b0, '0, '0, 1'b1);
            else expected_hits[$].last = 1'b1;
          end
          MODE_QUERY_SNAP: begin
            got = 0;
            foreach (snap_store[i]) begin
              if (!got && snap_store[i].tick == in_tick) begin
                add_hit(1'b1, snap_store[i].tick, snap_store[i].data, 1'b1);
                got = 1;
              end
            end
            if (!got) add_hit(1'b0, '0, '0, 1'b1);
          end
          MODE_COMPACT: begin
            compact_store(in_store, in_tick);
            compact_store(snap_store, in_tick);
            compact_store(evt_store, in_tick);
          end
          default: ;
        endcase
      end
    end
  end

  final begin
    if (expected_hits.size() != 0) $error("%0d results never arrived", expected_hits.size());
  end
endmodule

// ===== test/tick_sorted_history_buffer_tb.sv =====
// testbench top: drives commands and register writes, gives the verdict
`timescale 1ns / 1ps
module tick_sorted_history_buffer_tb;
  import tsh_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [MODE_W-1:0] in_mode = '0;
  logic [TICK_W-1:0] in_tick = '0;
  logic [DATA_W-1:0] in_entry_data = '0;
  logic out_valid, out_found, out_last;
  logic [TICK_W-1:0] out_found_tick;
  logic [DATA_W-1:0] out_found_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;
  int fail_count, pending_count;
  int idle_pct;
  int quiet_cycles;
  logic [TICK_W-1:0] tick_pool[4];

  localparam int WATCHDOG = 5000;

  always #5 clk = ~clk;

  tick_sorted_history_buffer uut (.*);
  tick_sorted_history_buffer_checker chk (.*);

  // watchdog on cycles with no transfer of any kind
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid || (psel && penable)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // start stays high after the transfer; the next command replaces it or the caller drops it
  task automatic send_cmd(logic [MODE_W-1:0] m, logic [TICK_W-1:0] t, logic [DATA_W-1:0] d);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_mode <= m;
    in_tick <= t;
    in_entry_data <= d;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic write_reg(logic addr_sel, logic [31:0] v);
    start <= 1'b0;
    // let the block drain, including trailing work of a push
    while (pending_count != 0 || busy) @(posedge clk);
    repeat (40) @(posedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {addr_sel, 2'b00}; pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [TICK_W-1:0] pick_tick();
    case ($urandom_range(3))
      0: return tick_pool[$urandom_range(3)];
      1: return tick_pool[$urandom_range(3)] + $urandom_range(3);
      2: return $urandom_range(20);
      default: return $urandom();
    endcase
  endfunction

  initial begin
    logic [MODE_W-1:0] m;
    idle_pct = 0;
    tick_pool[0] = 32'd5; tick_pool[1] = 32'd100;
    tick_pool[2] = 32'hFFFF_FFF0; tick_pool[3] = 32'h8000_0000;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: extremes, duplicates, snapshot replace, all modes
    send_cmd(MODE_QUERY_IN, 32'd0, '0);
    send_cmd(MODE_QUERY_SNAP, 32'd0, '0);
    send_cmd(MODE_PUSH_IN, 32'hFFFF_FFFF, '1);
    send_cmd(MODE_PUSH_IN, 32'd0, '0);
    send_cmd(MODE_PUSH_IN, 32'd7, 64'h1);
    send_cmd(MODE_PUSH_IN, 32'd7, 64'h2);
    send_cmd(MODE_QUERY_IN, 32'd7, '0);
    send_cmd(MODE_QUERY_IN, 32'hFFFF_FFFF, '0);
    send_cmd(MODE_PUSH_SNAP, 32'd9, 64'hAAAA_5555_AAAA_5555);
    send_cmd(MODE_PUSH_SNAP, 32'd9, 64'h5555_AAAA_5555_AAAA);
    send_cmd(MODE_QUERY_SNAP, 32'd9, '0);
    send_cmd(MODE_PUSH_EVT, 32'd3, '1);
    send_cmd(3'd6, 32'd1, '1);
    send_cmd(3'd7, 32'd1, '1);
    send_cmd(MODE_COMPACT, 32'd7, '0);
    send_cmd(MODE_QUERY_IN, 32'd0, '0);
    send_cmd(MODE_QUERY_IN, 32'd7, '0);
    write_reg(REG_KEEP, 32'd0);
    send_cmd(MODE_PUSH_EVT, 32'd4, '1);
    write_reg(REG_DEPTH, 32'd0);
    send_cmd(MODE_PUSH_IN, 32'd50, 64'h3);
    send_cmd(MODE_QUERY_IN, 32'd50, '0);
    write_reg(REG_DEPTH, 32'd31);
    write_reg(REG_KEEP, 32'd1);

    // random phases over several register settings and idle levels
    for (int ph = 0; ph < 9; ph++) begin
      case (ph % 4)
        0: idle_pct = 0;
        1: idle_pct = 62;
        2: idle_pct = 32;
        default: idle_pct = 62;
      endcase
      case (ph)
        0: write_reg(REG_DEPTH, 32'd16);
        1: write_reg(REG_DEPTH, 32'd3);
        2: write_reg(REG_DEPTH, 32'd31);
        3: write_reg(REG_DEPTH, 32'd1);
        4: write_reg(REG_DEPTH, 32'd0);
        5: write_reg(REG_DEPTH, 32'd8);
        6: write_reg(REG_DEPTH, 32'd17);
        default: write_reg(REG_DEPTH, $urandom_range(31));
      endcase
      write_reg(REG_KEEP, $urandom_range(1));
      for (int k = 0; k < 50; k++) begin
        case ($urandom_range(9))
          0, 1, 2: m = MODE_PUSH_IN;
          3, 4:    m = MODE_PUSH_SNAP;
          5:       m = MODE_PUSH_EVT;
          6:       m = MODE_QUERY_IN;
          7:       m = MODE_QUERY_SNAP;
          8:       m = ($urandom_range(3) == 0) ? MODE_COMPACT : MODE_QUERY_IN;
          default: m = ($urandom_range(7) == 0) ? 3'($urandom_range(6, 7)) : MODE_QUERY_SNAP;
        endcase
        send_cmd(m, pick_tick(), {$urandom(), $urandom()});
      end
    end

    // drain and settle
    start <= 1'b0;
    while (pending_count != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (fail_count == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tsh_pkg.sv
rtl/tsh_store.sv
rtl/tsh_datapath.sv
rtl/tsh_ctrl.sv
rtl/tick_sorted_history_buffer.sv
test/tick_sorted_history_buffer_checker.sv
test/tick_sorted_history_buffer_tb.sv
